@@ rtl/core/tksel_pkg.sv @@
// ----------------------------------------------------------------------------
// Top-k selection package
// Widths, register map, beat types and the link types of the insertion chain.
// ----------------------------------------------------------------------------
package tksel_pkg;

	localparam int DATA_W     = 32;
	localparam int K_W        = 5;
	localparam int MAX_K_DEF  = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [K_W-1:0] K_RESET = K_W'(16);

	// Register index of k_in_use; the index is paddr[2].
	localparam logic REG_K_IN_USE = 1'b0;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] kept_value;
		logic                     last_of_run;
	} out_beat_t;

	// What one cell shows a neighbour: its entry, whether it holds one, and
	// its comparison against the value being inserted.
	typedef struct packed {
		logic                     valid;
		logic                     flag;
		logic signed [DATA_W-1:0] value;
	} cell_link_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                     grow;
		logic                     replace;
		logic                     shift;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ rtl/core/top_k_select_min_heap.sv @@
// ----------------------------------------------------------------------------
// Top-k selection over a stream of signed values
// Keeps the k largest values of a run in a sorted chain of cells and reports
// them in ascending order when the run ends.
// ----------------------------------------------------------------------------
// Input beats carry a signed value and a last mark; output beats carry one
// kept value and a last_of_run mark. k_in_use is written through the APB
// port at address 0; zero acts as one and values above MAX_K act as MAX_K.
// Each input beat is taken without a stall: every cell compares its entry with
// the new value at once and shifts or loads in the same edge, so a run of
// values streams at one beat per cycle whatever k is.
// A beat marked last is processed like the others, and the first result is
// shown in the next cycle. The chain then shifts down one place per output
// beat taken. in_ready stays low from the last beat until the final result
// is taken; a stall simply holds the chain and the output beat.
// Reset empties the chain and sets k_in_use to 16.
// ----------------------------------------------------------------------------
module top_k_select_min_heap #(
	parameter int MAX_K = tksel_pkg::MAX_K_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tksel_pkg::in_beat_t               in_beat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tksel_pkg::out_beat_t              out_beat,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tksel_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [tksel_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tksel_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready
);

	localparam int CW   = $clog2(MAX_K + 1);
	localparam int CMPW = (CW > tksel_pkg::K_W) ? CW : tksel_pkg::K_W;

	logic [tksel_pkg::K_W-1:0] k_q;
	logic [CW-1:0]             count_q;
	logic                      report_q;

	logic [CMPW-1:0] k_ext;
	logic [CMPW-1:0] k_eff;
	logic [CMPW-1:0] count_ext;
	logic            in_take;
	logic            out_take;
	logic            has_room;
	logic            head_next_valid;

	tksel_pkg::cell_cmd_t  cmd;
	tksel_pkg::cell_link_t to_left  [MAX_K];
	tksel_pkg::cell_link_t to_right [MAX_K];

	// Configuration port
	assign pready = 1'b1;
	assign prdata = tksel_pkg::APB_DATA_W'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= tksel_pkg::K_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == tksel_pkg::REG_K_IN_USE)) begin
			k_q <= pwdata[tksel_pkg::K_W-1:0];
		end
	end

	assign k_ext     = CMPW'(k_q);
	assign count_ext = CMPW'(count_q);

	always_comb begin
		if (k_ext == '0) begin
			k_eff = CMPW'(1);
		end else if (k_ext > CMPW'(MAX_K)) begin
			k_eff = CMPW'(MAX_K);
		end else begin
			k_eff = k_ext;
		end
	end

	// Handshakes
	assign in_ready  = !report_q;
	assign in_take   = in_valid && in_ready;
	assign out_valid = report_q;
	assign out_take  = out_valid && out_ready;
	assign has_room  = count_ext < k_eff;

	// The head cell's lt flag tells whether the new value beats the minimum.
	assign cmd.grow    = in_take && has_room;
	assign cmd.replace = in_take && !has_room && to_left[0].flag;
	assign cmd.shift   = out_take;
	assign cmd.value   = in_beat.value;

	assign out_beat.kept_value  = to_right[0].value;
	assign out_beat.last_of_run = !head_next_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			report_q <= 1'b0;
		end else begin
			if (out_take && !head_next_valid) begin
				count_q  <= '0;
				report_q <= 1'b0;
			end else if (in_take) begin
				if (has_room) begin
					count_q <= count_q + CW'(1);
				end
				report_q <= in_beat.last;
			end
		end
	end

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		tksel_pkg::cell_link_t l_in;
		tksel_pkg::cell_link_t r_in;

		if (i == 0) begin : g_lo
			assign l_in = '{valid: 1'b1, flag: 1'b0, value: '0};
		end else begin : g_lo
			assign l_in = to_right[i-1];
		end

		if (i == MAX_K - 1) begin : g_hi
			assign r_in = '{valid: 1'b0, flag: 1'b0, value: '0};
		end else begin : g_hi
			assign r_in = to_left[i+1];
		end

		tksel_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.from_left  (l_in),
			.from_right (r_in),
			.to_left    (to_left[i]),
			.to_right   (to_right[i])
		);
	end

	assign head_next_valid = g_cell[0].r_in.valid;

endmodule

@@ rtl/core/tksel_cell.sv @@
// ----------------------------------------------------------------------------
// Top-k selection chain cell
// Holds one kept value of the ascending chain and moves it to or from its
// neighbours on insertion, replacement of the minimum, and readout.
// ----------------------------------------------------------------------------
module tksel_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tksel_pkg::cell_cmd_t  cmd,
	input  tksel_pkg::cell_link_t from_left,
	input  tksel_pkg::cell_link_t from_right,
	output tksel_pkg::cell_link_t to_left,
	output tksel_pkg::cell_link_t to_right
);

	logic                             valid_q;
	logic signed [tksel_pkg::DATA_W-1:0] value_q;
	logic                             gt;
	logic                             lt;

	// An empty cell counts as larger than anything, so growth fills the
	// first empty place when nothing kept is larger.
	assign gt = !valid_q || (value_q > cmd.value);
	assign lt = valid_q && (value_q < cmd.value);

	assign to_right = '{valid: valid_q, flag: gt, value: value_q};
	assign to_left  = '{valid: valid_q, flag: lt, value: value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= from_right.valid;
		end else if (cmd.grow) begin
			valid_q <= valid_q | from_left.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			value_q <= from_right.value;
		end else if (cmd.grow) begin
			if (gt) begin
				value_q <= from_left.flag ? from_left.value : cmd.value;
			end
		end else if (cmd.replace) begin
			if (from_right.flag) begin
				value_q <= from_right.value;
			end else if (lt) begin
				value_q <= cmd.value;
			end
		end
	end

endmodule

@@ rtl/core/tksel_checker.sv @@
// ----------------------------------------------------------------------------
// Top-k selection port checker
// Watches the ports of the top level for handshake and report sequencing.
// ----------------------------------------------------------------------------
module tksel_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input tksel_pkg::in_beat_t  in_beat,
	input logic                 out_valid,
	input logic                 out_ready,
	input tksel_pkg::out_beat_t out_beat
);

	// A result beat that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_beat))
		else $error("output beat changed while stalled");

	// Input is closed for the whole of a report.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input open during report");

	// A last beat always yields at least one result in the next cycle.
	a_report_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_beat.last |=> out_valid)
		else $error("report did not start after last beat");

	// The report ends exactly after the flagged beat.
	a_report_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_beat.last_of_run |=> !out_valid && in_ready)
		else $error("report did not end after final beat");

	a_report_goes_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_beat.last_of_run |=> out_valid)
		else $error("report stopped before final beat");

endmodule

bind top_k_select_min_heap tksel_checker u_tksel_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_beat   (in_beat),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_beat  (out_beat)
);
